// ----- src/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsr_pkg: shared definitions of the stream reassembler
// Field widths, default sizes and the item function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

  localparam int CAPACITY_DEFAULT   = 64;
  localparam int INDEX_BITS_DEFAULT = 32;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 7;
  localparam int PORT_IDX_W  = 32;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 56;
  localparam int FUNC_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DATA    = 2'd0,
    FUNC_END     = 2'd1,
    FUNC_CONSUME = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

endpackage

`default_nettype wire

// ----- src/tsr_byte_ram.sv -----
// ----------------------------------------------------------------------------
// tsr_byte_ram: payload store of the reassembly ring
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_byte_ram #(
  parameter int DEPTH  = tsr_pkg::CAPACITY_DEFAULT,
  parameter int ADDR_W = 6
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [tsr_pkg::BYTE_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [tsr_pkg::BYTE_W-1:0] rdata
);
  import tsr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/tsr_slot_flags.sv -----
// ----------------------------------------------------------------------------
// tsr_slot_flags: occupancy marks of the reassembly ring
// One flip-flop per slot, cleared at reset, with a lookup and a scan port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_slot_flags #(
  parameter int DEPTH  = tsr_pkg::CAPACITY_DEFAULT,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              set_en,
  input  wire logic [ADDR_W-1:0] set_slot,
  input  wire logic              clr_en,
  input  wire logic [ADDR_W-1:0] clr_slot,
  input  wire logic [ADDR_W-1:0] look_slot,
  output logic                   look_hit,
  input  wire logic [ADDR_W-1:0] scan_slot,
  output logic                   scan_hit
);
  import tsr_pkg::*;

  logic [DEPTH-1:0] flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      if (clr_en) begin
        flags[clr_slot] <= 1'b0;
      end
      if (set_en) begin
        flags[set_slot] <= 1'b1;
      end
    end
  end

  assign look_hit = flags[look_slot];
  assign scan_hit = flags[scan_slot];

endmodule

`default_nettype wire

// ----- src/tcp_stream_reassembler_core.sv -----
// ----------------------------------------------------------------------------
// tcp_stream_reassembler_core: out-of-order byte stream reassembly
// Parks indexed bytes in a ring and releases the contiguous run in order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_*       in         one item: function, index, byte, consume count
//  m_*       out        one result: released byte or status, tlast per item
//
// An item is taken in the idle state and evaluated in the next cycle. An
// item that releases nothing gives one status transfer from the status
// state that follows evaluation and waits there on m_tready. An item that
// completes a run is handled in two passes: the run length is first
// counted over the slot marks, one slot per cycle, so that every result
// already shows the final counts, and then the bytes are read from the
// payload RAM one per cycle while m_tready stays high. Reset clears the slot
// marks and the stream counters at once, so there is no clearing pass;
// payload RAM contents are only read behind a set mark.
// A stalled output holds its transfer; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_stream_reassembler_core #(
  parameter int CAPACITY   = tsr_pkg::CAPACITY_DEFAULT,
  parameter int INDEX_BITS = tsr_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // s_tdata: byte_index[31:0], byte_value[39:32], consume_count[46:40], pad
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [tsr_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: func[1:0]
  input  wire logic [tsr_pkg::FUNC_W-1:0]    s_tuser,
  // m_tdata: out_byte[7:0], out_index[39:8], stream_ended[40],
  //          pending_count[47:41], is_empty[48], pad
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [tsr_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: out_valid[0]
  output logic      [0:0]                    m_tuser,
  output logic                               m_tlast
);
  import tsr_pkg::*;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [COUNT_W-1:0] CAP_CNT   = COUNT_W'(CAPACITY);
  localparam logic [COUNT_W:0]   CAP_SUM   = (COUNT_W + 1)'(CAPACITY);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_STAT = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  // Control and stream state.
  state_t                  state;
  logic [SLOT_W-1:0]       head;
  logic [INDEX_BITS-1:0]   next_exp;
  logic [COUNT_W-1:0]      occupancy;
  logic [COUNT_W-1:0]      held;
  logic                    end_known;
  logic [INDEX_BITS-1:0]   end_pos;
  logic                    ended;

  // Item being processed and run bookkeeping.
  func_t                   it_func;
  logic [INDEX_BITS-1:0]   it_idx;
  logic [BYTE_W-1:0]       it_val;
  logic [COUNT_W-1:0]      it_cnt;
  logic [SLOT_W-1:0]       scan_ptr;
  logic [COUNT_W-1:0]      run_len;
  logic [INDEX_BITS-1:0]   scan_index;
  logic [COUNT_W-1:0]      remain;

  // The port index is cut or widened to the internal index width.
  logic [INDEX_BITS-1:0]   in_idx;
  logic [PORT_IDX_W-1:0]   out_idx;

  if (INDEX_BITS > PORT_IDX_W) begin : g_idx_wide
    assign in_idx  = {{(INDEX_BITS - PORT_IDX_W){1'b0}}, s_tdata[PORT_IDX_W-1:0]};
    assign out_idx = next_exp[PORT_IDX_W-1:0];
  end else if (INDEX_BITS == PORT_IDX_W) begin : g_idx_same
    assign in_idx  = s_tdata[PORT_IDX_W-1:0];
    assign out_idx = next_exp;
  end else begin : g_idx_narrow
    assign in_idx  = s_tdata[INDEX_BITS-1:0];
    assign out_idx = {{(PORT_IDX_W - INDEX_BITS){1'b0}}, next_exp};
  end

  // Window test and ring slot for a data byte.
  logic [INDEX_BITS-1:0] offset;
  logic [COUNT_W-1:0]    window;
  logic                  in_window;
  logic [COUNT_W:0]      slot_sum;
  logic [SLOT_W-1:0]     slot;
  logic                  slot_taken;
  logic                  take_byte;
  logic                  starts_run;

  assign offset    = it_idx - next_exp;
  assign window    = CAP_CNT - occupancy;
  assign in_window = ((offset >> COUNT_W) == '0) && (offset[COUNT_W-1:0] < window);
  assign slot_sum  = (COUNT_W + 1)'(head) + {1'b0, offset[COUNT_W-1:0]};
  assign slot      = (slot_sum >= CAP_SUM) ? SLOT_W'(slot_sum - CAP_SUM) : SLOT_W'(slot_sum);

  assign take_byte  = (state == ST_EVAL) && (it_func == FUNC_DATA) && in_window && !slot_taken;
  // The head slot is always empty between items, so only a byte at the
  // expected index can open a run.
  assign starts_run = take_byte && (offset == '0);

  // Run scan and emission control.
  logic                  scan_hit;
  logic                  scan_more;
  logic                  out_fire;
  logic                  last_byte;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [BYTE_W-1:0]     ram_rdata;
  logic [COUNT_W:0]      occ_sum;

  assign scan_more = (run_len != CAP_CNT) && scan_hit;
  assign out_fire  = m_tvalid && m_tready;
  assign last_byte = (remain == COUNT_W'(1));
  assign ram_re    = ((state == ST_SCAN) && !scan_more) ||
                     ((state == ST_EMIT) && out_fire && !last_byte);
  assign ram_raddr = (state == ST_SCAN) ? head : slot_inc(head);
  assign occ_sum   = {1'b0, occupancy} + {1'b0, run_len};

  tsr_byte_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (take_byte),
    .waddr (slot),
    .wdata (it_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsr_slot_flags #(
    .DEPTH  (CAPACITY),
    .ADDR_W (SLOT_W)
  ) u_flags (
    .clk       (clk),
    .rst       (rst),
    .set_en    (take_byte),
    .set_slot  (slot),
    .clr_en    ((state == ST_EMIT) && out_fire),
    .clr_slot  (head),
    .look_slot (slot),
    .look_hit  (slot_taken),
    .scan_slot (scan_ptr),
    .scan_hit  (scan_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      next_exp  <= '0;
      occupancy <= '0;
      held      <= '0;
      end_known <= 1'b0;
      end_pos   <= '0;
      ended     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          unique case (it_func)
            FUNC_DATA: begin
              if (take_byte) begin
                held <= held + COUNT_W'(1);
              end
              if (starts_run) begin
                state <= ST_SCAN;
              end else begin
                if (end_known && (end_pos <= next_exp)) begin
                  ended <= 1'b1;
                end
                state <= ST_STAT;
              end
            end
            FUNC_END: begin
              end_known <= 1'b1;
              end_pos   <= it_idx;
              if (it_idx <= next_exp) begin
                ended <= 1'b1;
              end
              state <= ST_STAT;
            end
            FUNC_CONSUME: begin
              occupancy <= (it_cnt >= occupancy) ? '0 : occupancy - it_cnt;
              state     <= ST_STAT;
            end
            default: begin
              state <= ST_STAT;
            end
          endcase
        end
        ST_STAT: begin
          if (out_fire) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          // At the end of the run the final counts are settled before the
          // first byte goes out; the head and index advance per transfer.
          if (!scan_more) begin
            held      <= held - run_len;
            occupancy <= (occ_sum > CAP_SUM) ? CAP_CNT : occ_sum[COUNT_W-1:0];
            if (end_known && (end_pos <= scan_index)) begin
              ended <= 1'b1;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            head     <= slot_inc(head);
            next_exp <= next_exp + INDEX_BITS'(1);
            if (last_byte) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture and run counters.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_tvalid) begin
      it_func <= func_t'(s_tuser);
      it_idx  <= in_idx;
      it_val  <= s_tdata[PORT_IDX_W +: BYTE_W];
      it_cnt  <= s_tdata[PORT_IDX_W + BYTE_W +: COUNT_W];
    end
    if (starts_run) begin
      scan_ptr   <= slot_inc(head);
      run_len    <= COUNT_W'(1);
      scan_index <= next_exp + INDEX_BITS'(1);
    end else if ((state == ST_SCAN) && scan_more) begin
      scan_ptr   <= slot_inc(scan_ptr);
      run_len    <= run_len + COUNT_W'(1);
      scan_index <= scan_index + INDEX_BITS'(1);
    end
    if ((state == ST_SCAN) && !scan_more) begin
      remain <= run_len;
    end else if ((state == ST_EMIT) && out_fire) begin
      remain <= remain - COUNT_W'(1);
    end
  end

  // Output transfer: a status result or one released byte.
  logic emitting;

  assign emitting   = (state == ST_EMIT);
  assign s_tready   = (state == ST_IDLE);
  assign m_tvalid   = (state == ST_STAT) || emitting;
  assign m_tuser[0] = emitting;
  assign m_tlast    = emitting ? last_byte : 1'b1;
  assign m_tdata    = {
    {(M_TDATA_W - BYTE_W - PORT_IDX_W - COUNT_W - 2){1'b0}},
    (held == '0),
    held,
    ended,
    emitting ? out_idx : '0,
    emitting ? ram_rdata : '0
  };

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the TCP stream reassembler core
// Drives data, end-marker, consume and no-op items over the slave stream,
// predicts the released bytes and status of every item, and compares each
// output transfer field by field while both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsr_pkg::*;

  localparam int RING            = 64;
  localparam int WATCHDOG_CYCLES = 2000000;
  localparam int MAX_PRINTS      = 60;
  localparam int RANDOM_ITEMS    = 130;
  localparam int DIRECTED_ROWS   = 16;

  // One output transfer as the bench sees it.
  typedef struct packed {
    logic        carries_byte;
    logic [7:0]  data;
    logic [31:0] index;
    logic        ended;
    logic [6:0]  held;
    logic        empty;
    logic        last_of_item;
  } release_t;

  // A directed row. Where typed is set, the row yields a single status
  // transfer whose ended and held values are written in by hand.
  typedef struct packed {
    func_t       f;
    logic [31:0] idx;
    logic [7:0]  val;
    logic [6:0]  cnt;
    bit          typed;
    logic        t_ended;
    logic [6:0]  t_held;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tcp_stream_reassembler_core #(
    .CAPACITY  (RING),
    .INDEX_BITS(32)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // --------------------------------------------------------------------------
  // Predictor state: the ring of parked bytes, its marks, and the counters
  // that decide the receive window and the end of the stream.
  // --------------------------------------------------------------------------
  logic [7:0]  ring_data [RING];
  bit          ring_mark [RING];
  logic [31:0] next_idx    = '0;
  int          outbuf_fill = 0;
  int          held_bytes  = 0;
  bit          eos_known   = 1'b0;
  logic [31:0] eos_pos     = '0;
  bit          eos_seen    = 1'b0;
  logic [5:0]  ring_head   = '0;

  release_t step_out [$];        // transfers caused by the latest item
  release_t queued_outputs [$];  // transfers still owed by the block

  int mismatches = 0;
  int results_checked = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // Works out the transfers one item causes and advances the predictor.
  function automatic void reassemble(input func_t f, input logic [31:0] idx,
                                     input logic [7:0] val, input logic [6:0] cnt);
    logic [31:0] off;
    int          win;
    int          n;
    int          k;
    logic [5:0]  slot;
    logic [7:0]  rel_data [RING];
    logic [31:0] rel_idx  [RING];
    release_t    r;
    n = 0;
    step_out.delete();
    case (f)
      FUNC_DATA: begin
        // The window shrinks by whatever the reader has not yet taken.
        off = idx - next_idx;
        win = RING - ((outbuf_fill > RING) ? RING : outbuf_fill);
        if (off < 32'(win)) begin
          slot = ring_head + off[5:0];
          if (!ring_mark[slot]) begin
            ring_data[slot] = val;
            ring_mark[slot] = 1'b1;
            held_bytes++;
          end
        end
        while (n < RING && ring_mark[ring_head]) begin
          rel_data[n] = ring_data[ring_head];
          rel_idx[n]  = next_idx;
          n++;
          ring_mark[ring_head] = 1'b0;
          if (held_bytes > 0) held_bytes--;
          if (outbuf_fill < RING) outbuf_fill++;
          next_idx++;
          ring_head++;
        end
      end
      FUNC_END: begin
        eos_known = 1'b1;
        eos_pos   = idx;
      end
      FUNC_CONSUME: begin
        outbuf_fill = (cnt >= outbuf_fill) ? 0 : outbuf_fill - cnt;
      end
      default: begin
      end
    endcase
    // The ended flag is sticky; other item kinds cannot change the outcome.
    if (eos_known && eos_pos <= next_idx) eos_seen = 1'b1;

    r.ended = eos_seen;
    r.held  = held_bytes[6:0];
    r.empty = (held_bytes == 0);
    if (n == 0) begin
      r.carries_byte = 1'b0;
      r.data         = '0;
      r.index        = '0;
      r.last_of_item = 1'b1;
      step_out = {step_out, r};
    end else begin
      for (k = 0; k < n; k++) begin
        r.carries_byte = 1'b1;
        r.data         = rel_data[k];
        r.index        = rel_idx[k];
        r.last_of_item = (k == n - 1);
        step_out = {step_out, r};
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_checked, what, got, want);
    mismatches++;
  endtask

  // Presents one item and holds it until the transfer completes. The
  // expectation is booked at the accepting edge. Between bursts the valid
  // line is sometimes dropped for a random gap.
  task automatic send_item(input func_t f, input logic [31:0] idx, input logic [7:0] val,
                           input logic [6:0] cnt, input bit typed = 1'b0,
                           input logic t_ended = 1'b0, input logic [6:0] t_held = '0);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {1'b0, cnt, val, idx};
    do @(posedge clk); while (!s_tready);
    reassemble(f, idx, val, cnt);
    if (typed)
      queued_outputs = {queued_outputs,
                        release_t'({1'b0, 8'h00, 32'h0, t_ended, t_held,
                                    t_held == 7'd0, 1'b1})};
    else
      queued_outputs = {queued_outputs, step_out};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: the ready line cycles through four regimes in turn, namely
  // always ready, coin-toss ready, ready one cycle in four, and mostly
  // ready with occasional long stalls.
  // --------------------------------------------------------------------------
  logic [8:0] rx_phase = '0;
  int         stall_left = 0;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 9'd1;
    case (rx_phase[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 1) == 0);
      2'd2: m_tready <= (rx_phase[1:0] == 2'd0);
      default: begin
        if (stall_left > 0) begin
          m_tready   <= 1'b0;
          stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
          m_tready   <= 1'b0;
          stall_left <= $urandom_range(3, 9);
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output checker: every completed master transfer is matched against the
  // oldest expectation.
  // --------------------------------------------------------------------------
  release_t got_out;
  release_t want_out;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_out.carries_byte = m_tuser[0];
      got_out.data         = m_tdata[7:0];
      got_out.index        = m_tdata[39:8];
      got_out.ended        = m_tdata[40];
      got_out.held         = m_tdata[47:41];
      got_out.empty        = m_tdata[48];
      got_out.last_of_item = m_tlast;
      if (queued_outputs.size() == 0) begin
        flag_mismatch("unexpected transfer", 64'(m_tdata), '0);
      end else begin
        want_out = queued_outputs.pop_front();
        if (got_out.carries_byte !== want_out.carries_byte)
          flag_mismatch("out_valid", 64'(got_out.carries_byte),
                        64'(want_out.carries_byte));
        if (got_out.data !== want_out.data)
          flag_mismatch("out_byte", 64'(got_out.data), 64'(want_out.data));
        if (got_out.index !== want_out.index)
          flag_mismatch("out_index", 64'(got_out.index), 64'(want_out.index));
        if (got_out.ended !== want_out.ended)
          flag_mismatch("stream_ended", 64'(got_out.ended), 64'(want_out.ended));
        if (got_out.held !== want_out.held)
          flag_mismatch("pending_count", 64'(got_out.held), 64'(want_out.held));
        if (got_out.empty !== want_out.empty)
          flag_mismatch("is_empty", 64'(got_out.empty), 64'(want_out.empty));
        if (got_out.last_of_item !== want_out.last_of_item)
          flag_mismatch("tlast", 64'(got_out.last_of_item),
                        64'(want_out.last_of_item));
      end
      results_checked++;
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed rows. Starting from reset: a no-op, a byte held out of order, a
  // duplicate, a stale index, the window edge, a run release, a byte lost to
  // the window shrinking behind unread output, zero and over-consume, an end
  // marker ahead of the stream that is reached by a later release, and a
  // later marker that cannot clear the sticky ended flag.
  // --------------------------------------------------------------------------
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_NONE,    32'h0000_0000, 8'h00, 7'd0,   1'b1, 1'b0, 7'd0},
    '{FUNC_DATA,    32'd1,         8'hFF, 7'd0,   1'b1, 1'b0, 7'd1},
    '{FUNC_DATA,    32'd1,         8'h00, 7'd0,   1'b1, 1'b0, 7'd1},
    '{FUNC_DATA,    32'hFFFF_FFFF, 8'h5A, 7'd127, 1'b1, 1'b0, 7'd1},
    '{FUNC_DATA,    32'd64,        8'h33, 7'd0,   1'b1, 1'b0, 7'd1},
    '{FUNC_DATA,    32'd63,        8'h80, 7'd0,   1'b1, 1'b0, 7'd2},
    '{FUNC_DATA,    32'd0,         8'h00, 7'd0,   1'b0, 1'b0, 7'd0},
    '{FUNC_DATA,    32'd65,        8'hC3, 7'd0,   1'b1, 1'b0, 7'd1},
    '{FUNC_CONSUME, 32'd0,         8'h00, 7'd0,   1'b1, 1'b0, 7'd1},
    '{FUNC_CONSUME, 32'hFFFF_FFFF, 8'hFF, 7'd127, 1'b1, 1'b0, 7'd1},
    '{FUNC_END,     32'd4,         8'h00, 7'd0,   1'b1, 1'b0, 7'd1},
    '{FUNC_DATA,    32'd3,         8'h11, 7'd0,   1'b1, 1'b0, 7'd2},
    '{FUNC_DATA,    32'd2,         8'h22, 7'd0,   1'b0, 1'b0, 7'd0},
    '{FUNC_END,     32'hFFFF_FFFF, 8'h00, 7'd0,   1'b1, 1'b1, 7'd1},
    '{FUNC_NONE,    32'hFFFF_FFFF, 8'hFF, 7'd127, 1'b1, 1'b1, 7'd1},
    '{FUNC_CONSUME, 32'd0,         8'h00, 7'd64,  1'b1, 1'b1, 7'd1}
  };

  initial begin
    int          pick;
    int          win;
    int          off;
    func_t       f;
    logic [31:0] idx;
    foreach (ring_mark[i]) ring_mark[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].f, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].cnt, directed_rows[i].typed,
                directed_rows[i].t_ended, directed_rows[i].t_held);

    // Fill a whole empty window back to front, then supply the head byte so
    // that one item releases the largest possible run.
    send_item(FUNC_CONSUME, $urandom, 8'($urandom), 7'd127);
    for (off = RING - 1; off >= 0; off--)
      send_item(FUNC_DATA, next_idx + 32'(off), 8'($urandom),
                7'($urandom_range(0, 127)));

    // Mostly in-window bytes in random order, with consumes to keep the
    // window open, and a sprinkling of stale, far, edge and junk items.
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      win  = RING - outbuf_fill;
      f    = FUNC_DATA;
      if (pick < 50) begin
        off = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, win + 1);
        idx = next_idx + 32'(off);
      end else if (pick < 64) begin
        f   = FUNC_CONSUME;
        idx = $urandom;
      end else if (pick < 72) begin
        idx = next_idx - 32'($urandom_range(1, 40));
      end else if (pick < 80) begin
        idx = $urandom;
      end else if (pick < 87) begin
        f   = FUNC_END;
        idx = $urandom_range(0, 1) ? next_idx + 32'($urandom_range(0, 80)) : $urandom;
      end else if (pick < 93) begin
        f   = FUNC_NONE;
        idx = $urandom;
      end else begin
        idx = next_idx + 32'(win) - 32'($urandom_range(0, 1));
      end
      if (f == FUNC_CONSUME && $urandom_range(0, 3) != 0)
        send_item(f, idx, 8'($urandom), 7'($urandom_range(0, 40)));
      else
        send_item(f, idx, 8'($urandom), 7'($urandom_range(0, 127)));
    end
    s_tvalid <= 1'b0;

    while (queued_outputs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
